@@ hdl/sgx_pkg.sv @@
package sgx_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_CHANNELS_DEF = 4;
    localparam int ROW_LIMIT        = 4096;
    localparam int CH_W             = 8;
    localparam int GRAD_W           = 11;
    localparam int COL_W            = 10;
    localparam int ROW_W            = 12;
    localparam int WIDTH_REG_W      = 11;
    localparam int HEIGHT_REG_W     = 13;
    localparam int CHAN_REG_W       = 3;
    localparam int CFG_ADDR_W       = 2;
    localparam int CFG_DATA_W       = 13;

    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNELS = 2'd2;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET    = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET   = 13'd480;
    localparam logic [CHAN_REG_W-1:0]   CHANNELS_RESET = 3'd1;

    // three rows of one channel of one column
    typedef struct packed {
        logic [CH_W-1:0] top;
        logic [CH_W-1:0] mid;
        logic [CH_W-1:0] bot;
    } sgx_col_t;

    // control for one result out of the issue stage
    typedef struct packed {
        logic             lower;
        logic             top_mirror;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } sgx_ctl_t;

endpackage

@@ hdl/sgx_lane.sv @@
module sgx_lane
    import sgx_pkg::*;
(
    input  logic                     lower,
    input  logic                     top_mirror,
    input  sgx_col_t                 lc,
    input  sgx_col_t                 mc,
    input  sgx_col_t                 rc,
    output logic signed [GRAD_W-1:0] gx,
    output logic signed [GRAD_W-1:0] gy
);

    logic signed [GRAD_W-1:0] a0, a1, a2, b0, b2, d0, d1, d2;

    always_comb
    begin
        if (lower)
        begin
            a0 = GRAD_W'(lc.mid); a1 = GRAD_W'(lc.bot); a2 = GRAD_W'(lc.mid);
            b0 = GRAD_W'(mc.mid); b2 = GRAD_W'(mc.mid);
            d0 = GRAD_W'(rc.mid); d1 = GRAD_W'(rc.bot); d2 = GRAD_W'(rc.mid);
        end
        else
        begin
            a0 = top_mirror ? GRAD_W'(lc.bot) : GRAD_W'(lc.top);
            a1 = GRAD_W'(lc.mid); a2 = GRAD_W'(lc.bot);
            b0 = top_mirror ? GRAD_W'(mc.bot) : GRAD_W'(mc.top);
            b2 = GRAD_W'(mc.bot);
            d0 = top_mirror ? GRAD_W'(rc.bot) : GRAD_W'(rc.top);
            d1 = GRAD_W'(rc.mid); d2 = GRAD_W'(rc.bot);
        end
        gx = (d0 - a0) + ((d1 - a1) <<< 1) + (d2 - a2);
        gy = (a2 - a0) + ((b2 - b0) <<< 1) + (d2 - d0);
    end

endmodule

@@ hdl/sgx_merge.sv @@
module sgx_merge
    import sgx_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  sgx_ctl_t                 in_ctl,
    input  logic [4*GRAD_W-1:0]      in_gx,
    input  logic [4*GRAD_W-1:0]      in_gy,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [8*GRAD_W+COL_W+ROW_W-1:0] out_data,
    output logic                     out_last
);

    localparam int DW = 8*GRAD_W+COL_W+ROW_W;

    logic          valid_reg, valid_next;
    logic [DW-1:0] data_reg, data_next;
    logic          last_reg, last_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            data_next  = {in_ctl.row, in_ctl.col, in_gy, in_gx};
            last_next  = in_ctl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

@@ hdl/sobel_gradient_xy.sv @@
// channel   dir  handshake                fields
// s_axis    in   s_axis_tvalid/tready     tdata: sample_0..sample_3
// m_axis    out  m_axis_tvalid/tready     tdata: grad_x_0..3 grad_y_0..3 out_col out_row
//                                          tlast: last_of_run
// cfg       in   cfg_we                   cfg_addr, cfg_data
// an item gives zero to four results; each issued result appears on m_axis in the next cycle
// one result issues per cycle while m_axis does not stall, so throughput is one item per cycle
// except on the last column or last row, where an item gives two or four results in turn
// the line store read for column c is registered once, in stage a
// reset clears counters, window and output valid; line stores are not cleared
// m_axis stalls propagate back through the output register to s_axis_tready
module sobel_gradient_xy
    import sgx_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [31:0]             s_axis_tdata,   // sample_0, sample_1, sample_2, sample_3
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [111:0]            m_axis_tdata,   // grad_x_0..3, grad_y_0..3, out_col, out_row, zero pad
    output logic                    m_axis_tlast,   // last_of_run
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = 32;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [CHAN_REG_W-1:0]   chans_reg;

    logic [PW-1:0] line1_mem [MAX_WIDTH];
    logic [PW-1:0] line2_mem [MAX_WIDTH];

    // stage a: accepted pixel and its position, line read in flight
    logic          a_valid_reg;
    logic [PW-1:0] a_pix_reg;
    logic [COL_W-1:0] a_col_reg;
    logic [ROW_W-1:0] a_row_reg;
    logic [PW-1:0] rd1_reg, rd2_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PW-1:0] w0_top_reg, w0_mid_reg, w0_bot_reg;
    logic [PW-1:0] w1_top_reg, w1_mid_reg, w1_bot_reg;
    logic [1:0]    phase_reg, phase_next;

    logic [COL_W:0]  w_eff;
    logic [ROW_W:0]  h_eff;
    logic [2:0]      n_ch;
    logic [PW-1:0]   cmask;
    logic            take, a_done, stage_ready, m_ready;
    logic            last_row, last_col, emit_ok;
    logic            cfg_restart;
    logic [1:0]      n_res;
    logic            iss_valid;
    sgx_ctl_t        iss_ctl;
    logic [PW-1:0]   lt, lm, lb, mt, mm, mb, rt, rm, rb;
    logic [4*GRAD_W-1:0] gx_bus, gy_bus;
    logic [8*GRAD_W+COL_W+ROW_W-1:0] mdata;

    always_comb
    begin
        if (width_reg < 11'd2)
            w_eff = 11'd2;
        else if (width_reg > 11'(MAX_WIDTH))
            w_eff = 11'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg < 13'd2)
            h_eff = 13'd2;
        else if (height_reg > 13'(ROW_LIMIT))
            h_eff = 13'(ROW_LIMIT);
        else
            h_eff = height_reg;
        n_ch = (chans_reg > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : chans_reg;
        for (int k = 0; k < 4; k++)
            cmask[8*k +: 8] = (3'(k) < n_ch) ? 8'hFF : 8'h00;
    end

    assign cfg_restart = cfg_we && (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT
                                    || cfg_addr == REG_CHANNELS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            chans_reg  <= CHANNELS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WIDTH:    width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_HEIGHT:   height_reg <= cfg_data;
                REG_CHANNELS: chans_reg  <= cfg_data[CHAN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // result sequencing for the item in stage a
    always_comb
    begin
        last_row = ({1'b0, a_row_reg} == h_eff - 13'd1);
        last_col = ({1'b0, a_col_reg} == w_eff - 11'd1);
        emit_ok  = (a_row_reg != '0) && (a_col_reg != '0);
        n_res    = {last_col, last_row} == 2'b11 ? 2'd3 :
                   (last_col || last_row) ? 2'd1 : 2'd0;
        iss_valid = a_valid_reg && emit_ok;
        iss_ctl.lower      = phase_reg[0] && last_row;
        iss_ctl.top_mirror = (a_row_reg == 12'd1) && !iss_ctl.lower;
        iss_ctl.col  = (last_col && (last_row ? phase_reg[1] : phase_reg[0]))
                       ? a_col_reg : a_col_reg - 10'd1;
        iss_ctl.row  = iss_ctl.lower ? a_row_reg : a_row_reg - 12'd1;
        iss_ctl.last = (phase_reg == n_res);
        a_done = !a_valid_reg || !emit_ok || (m_ready && phase_reg == n_res);
        phase_next = phase_reg;
        if (a_valid_reg && emit_ok && m_ready)
            phase_next = (phase_reg == n_res) ? 2'd0 : phase_reg + 2'd1;
    end

    // window columns: second column of a result uses pair (w1, new, w1)
    always_comb
    begin
        logic second;
        second = last_col && (last_row ? phase_reg[1] : phase_reg[0]);
        if (second)
        begin
            lt = w1_top_reg; lm = w1_mid_reg; lb = w1_bot_reg;
            mt = rd2_reg;    mm = rd1_reg;    mb = a_pix_reg;
            rt = w1_top_reg; rm = w1_mid_reg; rb = w1_bot_reg;
        end
        else
        begin
            if (a_col_reg == 10'd1)
            begin
                lt = rd2_reg; lm = rd1_reg; lb = a_pix_reg;
            end
            else
            begin
                lt = w0_top_reg; lm = w0_mid_reg; lb = w0_bot_reg;
            end
            mt = w1_top_reg; mm = w1_mid_reg; mb = w1_bot_reg;
            rt = rd2_reg;    rm = rd1_reg;    rb = a_pix_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            sgx_lane u_lane (
                .lower      (iss_ctl.lower),
                .top_mirror (iss_ctl.top_mirror),
                .lc         ({lt[8*g +: 8], lm[8*g +: 8], lb[8*g +: 8]}),
                .mc         ({mt[8*g +: 8], mm[8*g +: 8], mb[8*g +: 8]}),
                .rc         ({rt[8*g +: 8], rm[8*g +: 8], rb[8*g +: 8]}),
                .gx         (gx_bus[GRAD_W*g +: GRAD_W]),
                .gy         (gy_bus[GRAD_W*g +: GRAD_W])
            );
        end
    endgenerate

    sgx_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (iss_valid),
        .in_ready  (m_ready),
        .in_ctl    (iss_ctl),
        .in_gx     (gx_bus),
        .in_gy     (gy_bus),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (mdata),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, mdata};

    assign stage_ready   = a_done;
    assign s_axis_tready = stage_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if ({1'b0, col_reg} + 11'd1 >= w_eff)
        begin
            col_next = '0;
            row_next = ({1'b0, row_reg} == h_eff - 13'd1) ? '0 : row_reg + 12'd1;
        end
        else
        begin
            col_next = col_reg + 10'd1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            phase_reg   <= '0;
            w0_top_reg <= '0; w0_mid_reg <= '0; w0_bot_reg <= '0;
            w1_top_reg <= '0; w1_mid_reg <= '0; w1_bot_reg <= '0;
        end
        else if (cfg_restart)
        begin
            a_valid_reg <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            phase_reg   <= '0;
            w0_top_reg <= '0; w0_mid_reg <= '0; w0_bot_reg <= '0;
            w1_top_reg <= '0; w1_mid_reg <= '0; w1_bot_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (a_done && a_valid_reg)
            begin
                if (last_col)
                begin
                    w0_top_reg <= '0; w0_mid_reg <= '0; w0_bot_reg <= '0;
                    w1_top_reg <= '0; w1_mid_reg <= '0; w1_bot_reg <= '0;
                end
                else
                begin
                    w0_top_reg <= w1_top_reg; w0_mid_reg <= w1_mid_reg;
                    w0_bot_reg <= w1_bot_reg;
                    w1_top_reg <= rd2_reg; w1_mid_reg <= rd1_reg;
                    w1_bot_reg <= a_pix_reg;
                end
            end
            if (a_done)
                a_valid_reg <= take;
            if (take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_pix_reg <= s_axis_tdata & cmask;
            a_col_reg <= col_reg;
            a_row_reg <= row_reg;
            rd1_reg   <= line1_mem[col_reg[AW-1:0]];
            rd2_reg   <= line2_mem[col_reg[AW-1:0]];
        end
        if (a_done && a_valid_reg)
        begin
            line1_mem[a_col_reg[AW-1:0]] <= a_pix_reg;
            line2_mem[a_col_reg[AW-1:0]] <= rd1_reg;
        end
    end

endmodule

@@ hdl/sgx_check.sv @@
module sgx_check
    import sgx_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic         m_axis_tlast
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // pad bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[111:110] == 2'b00)
        else $error("pad bits set");

    // an accepted non-final result keeps m_axis_tvalid high after it
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid)
        else $error("run broken");

endmodule

bind sobel_gradient_xy sgx_check u_sgx_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ verif/sobel_gradient_xy_checker.sv @@
`timescale 1ns / 1ps

module sobel_gradient_xy_checker
    import sgx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [111:0]          m_axis_tdata,
    input  logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    pending_count
);

    // bit 110 last_of_run, bits 109:0 as in m_axis_tdata
    logic [110:0] grad_q[$];

    logic [31:0] row_above[MAX_WIDTH_DEF];
    logic [31:0] row_two_above[MAX_WIDTH_DEF];
    logic [2:0][31:0] win_old;
    logic [2:0][31:0] win_new;
    int col_cnt;
    int row_cnt;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [CHAN_REG_W-1:0]   chan_reg;

    initial
    begin
        error_count = 0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        chan_reg = CHANNELS_RESET;
        for (int i = 0; i < MAX_WIDTH_DEF; i++)
        begin
            row_above[i] = '0;
            row_two_above[i] = '0;
        end
        restart_frame();
    end

    assign pending_count = grad_q.size();

    function automatic void restart_frame();
        col_cnt = 0;
        row_cnt = 0;
        win_old = '0;
        win_new = '0;
    endfunction

    function automatic logic [2:0][31:0] pick_rows(logic [2:0][31:0] col, logic lower,
                                                   logic top_mirror);
        logic [2:0][31:0] r;
        if (lower)
        begin
            r[0] = col[1];
            r[1] = col[2];
            r[2] = col[1];
        end
        else
        begin
            r[0] = top_mirror ? col[2] : col[0];
            r[1] = col[1];
            r[2] = col[2];
        end
        return r;
    endfunction

    function automatic logic [110:0] sobel_at(logic [2:0][31:0] lc, logic [2:0][31:0] mc,
                                              logic [2:0][31:0] rc, logic lower,
                                              logic top_mirror, int col, int row);
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [2:0][31:0] d;
        logic [110:0] res;
        int gx;
        int gy;
        a = pick_rows(lc, lower, top_mirror);
        b = pick_rows(mc, lower, top_mirror);
        d = pick_rows(rc, lower, top_mirror);
        res = '0;
        for (int k = 0; k < 4; k++)
        begin
            gx = (int'(d[0][8*k+:8]) - int'(a[0][8*k+:8]))
               + 2 * (int'(d[1][8*k+:8]) - int'(a[1][8*k+:8]))
               + (int'(d[2][8*k+:8]) - int'(a[2][8*k+:8]));
            gy = (int'(a[2][8*k+:8]) - int'(a[0][8*k+:8]))
               + 2 * (int'(b[2][8*k+:8]) - int'(b[0][8*k+:8]))
               + (int'(d[2][8*k+:8]) - int'(d[0][8*k+:8]));
            res[11*k+:11] = gx[10:0];
            res[44+11*k+:11] = gy[10:0];
        end
        res[88+:10] = col[9:0];
        res[98+:12] = row[11:0];
        return res;
    endfunction

    function automatic void predict_pixel(logic [31:0] data);
        int w;
        int h;
        int c;
        int r;
        int n;
        logic [63:0] mask;
        logic [31:0] pix;
        logic [2:0][31:0] newc;
        logic [2:0][31:0] left;
        logic [110:0] res[4];
        logic last_row;
        logic top_mirror;
        w = width_reg < 2 ? 2 : (width_reg > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : int'(width_reg));
        h = height_reg < 2 ? 2 : (height_reg > ROW_LIMIT ? ROW_LIMIT : int'(height_reg));
        n = chan_reg > 4 ? 4 : int'(chan_reg);
        mask = (64'd1 << (8 * n)) - 1;
        c = col_cnt >= w ? w - 1 : col_cnt;
        r = row_cnt >= h ? h - 1 : row_cnt;
        pix = data & mask[31:0];
        newc[0] = row_two_above[c];
        newc[1] = row_above[c];
        newc[2] = pix;
        last_row = (r == h - 1);
        top_mirror = (r == 1);
        n = 0;
        if (r >= 1 && c >= 1)
        begin
            left = (c == 1) ? newc : win_old;
            res[n++] = sobel_at(left, win_new, newc, 1'b0, top_mirror, c - 1, r - 1);
            if (last_row)
                res[n++] = sobel_at(left, win_new, newc, 1'b1, 1'b0, c - 1, r);
            if (c == w - 1)
            begin
                res[n++] = sobel_at(win_new, newc, win_new, 1'b0, top_mirror, c, r - 1);
                if (last_row)
                    res[n++] = sobel_at(win_new, newc, win_new, 1'b1, 1'b0, c, r);
            end
            res[n-1][110] = 1'b1;
            for (int i = 0; i < n; i++)
                grad_q.push_back(res[i]);
        end
        row_two_above[c] = newc[1];
        row_above[c] = pix;
        win_old = win_new;
        win_new = newc;
        if (c + 1 >= w)
        begin
            col_cnt = 0;
            win_old = '0;
            win_new = '0;
            row_cnt = last_row ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
            row_cnt = r;
        end
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        logic [110:0] want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_WIDTH:    width_reg = cfg_data[WIDTH_REG_W-1:0];
                    REG_HEIGHT:   height_reg = cfg_data[HEIGHT_REG_W-1:0];
                    REG_CHANNELS: chan_reg = cfg_data[CHAN_REG_W-1:0];
                    default:      ;
                endcase
                if (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT || cfg_addr == REG_CHANNELS)
                    restart_frame();
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (grad_q.size() == 0)
                    report_mismatch("unexpected item", 1, 0);
                else
                begin
                    want = grad_q.pop_front();
                    for (int k = 0; k < 8; k++)
                        if (m_axis_tdata[11*k+:11] !== want[11*k+:11])
                            report_mismatch($sformatf("grad_%s_%0d", k < 4 ? "x" : "y", k % 4),
                                            int'($signed(m_axis_tdata[11*k+:11])),
                                            int'($signed(want[11*k+:11])));
                    if (m_axis_tdata[88+:10] !== want[88+:10])
                        report_mismatch("out_col", m_axis_tdata[88+:10], want[88+:10]);
                    if (m_axis_tdata[98+:12] !== want[98+:12])
                        report_mismatch("out_row", m_axis_tdata[98+:12], want[98+:12]);
                    if (m_axis_tlast !== want[110])
                        report_mismatch("last_of_run", m_axis_tlast, want[110]);
                end
            end
        end
    end

endmodule

@@ verif/sobel_gradient_xy_test.sv @@
`timescale 1ns / 1ps

module sobel_gradient_xy_test;
    import sgx_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [111:0]          m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    error_count;
    int                    pending_count;
    logic                  steady = 1'b0;
    int                    pixels_sent = 0;

    always #5 clk = ~clk;

    sobel_gradient_xy u_top (.*);

    sobel_gradient_xy_checker u_checker (.*);

    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 31);

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, int value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic set_frame(int w, int h, int ch);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_CHANNELS, ch);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(logic [31:0] data);
        if (!steady && $urandom_range(99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 31);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pixels_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        int w;
        int h;
        int n;
        int phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // horizontal extremes, channels of opposite sign
        set_frame(4, 3, 4);
        for (int i = 0; i < 12; i++)
            send_pixel((i % 4) >= 2 ? 32'h00FF00FF : 32'hFF00FF00);
        drain();
        // vertical extremes
        set_frame(2, 3, 4);
        for (int i = 0; i < 6; i++)
            send_pixel(i < 2 ? 32'hFF00FF00 : (i < 4 ? 32'h5A5A5A5A : 32'h00FF00FF));
        drain();
        // ignored register index, then a partial frame that the next configuration write restarts
        write_reg(2'd3, 5);
        cfg_we <= 1'b0;
        for (int i = 0; i < 5; i++)
            send_pixel($urandom);
        drain();

        phase = 0;
        while (pixels_sent < 400)
        begin
            steady <= (phase == 3);
            case ($urandom_range(5))
                0: w = $urandom_range(1);
                1: w = 2;
                default: w = $urandom_range(3, 12);
            endcase
            case ($urandom_range(5))
                0: h = $urandom_range(1);
                1: h = $urandom_range(1) ? 4096 : 8191;
                default: h = $urandom_range(2, 6);
            endcase
            set_frame(w, h, $urandom_range(7));
            w = w < 2 ? 2 : w;
            h = h < 2 ? 2 : (h > 20 ? 6 : h);
            n = w * h * $urandom_range(1, 2);
            if ($urandom_range(5) == 0)
                n = n + $urandom_range(1, w * h - 1);
            for (int i = 0; i < n; i++)
                send_pixel($urandom);
            drain();
            phase++;
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/sgx_pkg.sv
hdl/sgx_lane.sv
hdl/sgx_merge.sv
hdl/sobel_gradient_xy.sv
hdl/sgx_check.sv
verif/sobel_gradient_xy_checker.sv
verif/sobel_gradient_xy_test.sv
